[rtl/pcc_pkg.sv]
// Shared types, constants and the CRC byte update for the packet CRC16 checker.
`default_nettype none

package pcc_pkg;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam int          MIN_LENGTH = 4;
  localparam logic [7:0]  HEADER_RST = 8'hAA;

  typedef enum logic [1:0] {
    VERDICT_OK        = 2'd0,
    VERDICT_TOO_SHORT = 2'd1,
    VERDICT_BAD_HDR   = 2'd2,
    VERDICT_CRC_ERR   = 2'd3
  } verdict_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [7:0]  packet_type;
    logic [15:0] payload_length;
  } result_t;

  // CRC-16-CCITT over one byte, MSB first, eight unrolled shift steps.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/packet_crc16_checker.sv]
// Top level of the packet CRC16 checker: byte datapath, verdict logic and output queue.
// Takes one packet word per clock cycle while in_stall is low, with no gaps required
// between packets. Each word updates the CRC through an unrolled eight-bit CRC-16-CCITT
// step (poly 0x1021, init 0xFFFF); a two-word hold window keeps the trailing CRC bytes
// out of the sum. On the word marked last, the verdict (too short, bad header, CRC
// mismatch, ok), the type byte and the payload length are registered for the result
// channel. A two-entry output queue lets input continue while one result waits; in_stall
// rises only when both entries are full. The header register is read at the last word.
`default_nettype none

module packet_crc16_checker #(
  parameter int LENGTH_BITS = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_wr_en,
  input  wire  [7:0]  cfg_wr_data,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_data_byte,
  input  wire         in_last_byte,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_verdict,
  output logic [7:0]  out_packet_type,
  output logic [15:0] out_payload_length
);

  localparam int PlenW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

  logic [7:0]             header_r;
  logic [15:0]            crc_r, crc_nxt;
  logic [7:0]             hold0_r, hold0_nxt;
  logic [7:0]             hold1_r, hold1_nxt;
  logic [LENGTH_BITS-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [7:0]             first_r, first_nxt;
  logic [7:0]             type_r, type_nxt;

  logic                   in_acc;
  logic                   push;
  logic                   pop;
  logic [15:0]            rx_crc;
  logic [PlenW-1:0]       plen_wide;
  pcc_pkg::result_t       res_nxt;
  pcc_pkg::result_t       out_r;
  pcc_pkg::result_t       skid_r;
  logic                   out_valid_r;
  logic                   skid_valid_r;

  assign in_acc = in_valid && !in_stall;
  assign push   = in_acc && in_last_byte;
  assign pop    = out_valid_r && !out_stall;

  // Packet datapath: next state as if the packet goes on.
  always_comb begin
    crc_nxt   = crc_r;
    first_nxt = first_r;
    type_nxt  = type_r;
    if (cnt_r >= LENGTH_BITS'(2)) begin
      crc_nxt = pcc_pkg::crc16_byte(crc_r, hold0_r);
    end
    hold0_nxt = hold1_r;
    hold1_nxt = in_data_byte;
    if (cnt_r == '0) begin
      first_nxt = in_data_byte;
    end
    if (cnt_r == LENGTH_BITS'(1)) begin
      type_nxt = in_data_byte;
    end
    // saturate at all ones
    cnt_inc = (cnt_r != '1) ? cnt_r + LENGTH_BITS'(1) : cnt_r;
    cnt_nxt = cnt_inc;
  end

  // Verdict at the last word.
  always_comb begin
    rx_crc    = {hold1_r, in_data_byte};
    plen_wide = PlenW'(cnt_inc) - PlenW'(pcc_pkg::MIN_LENGTH);
    res_nxt   = '0;
    if (cnt_inc < LENGTH_BITS'(pcc_pkg::MIN_LENGTH)) begin
      res_nxt.verdict        = pcc_pkg::VERDICT_TOO_SHORT;
      res_nxt.packet_type    = 8'h00;
      res_nxt.payload_length = 16'h0000;
    end else begin
      if (plen_wide > PlenW'(16'hFFFF)) begin
        res_nxt.payload_length = 16'hFFFF;
      end else begin
        res_nxt.payload_length = plen_wide[15:0];
      end
      if (first_nxt != header_r) begin
        res_nxt.verdict     = pcc_pkg::VERDICT_BAD_HDR;
        res_nxt.packet_type = 8'h00;
      end else begin
        res_nxt.packet_type = type_nxt;
        res_nxt.verdict     = (rx_crc == crc_nxt) ? pcc_pkg::VERDICT_OK
                                                  : pcc_pkg::VERDICT_CRC_ERR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= pcc_pkg::HEADER_RST;
    end else if (cfg_wr_en) begin
      header_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= pcc_pkg::CRC_INIT;
      hold0_r <= '0;
      hold1_r <= '0;
      cnt_r   <= '0;
      first_r <= '0;
      type_r  <= '0;
    end else if (in_acc) begin
      if (in_last_byte) begin
        // drop packet state for the next packet
        crc_r   <= pcc_pkg::CRC_INIT;
        hold0_r <= '0;
        hold1_r <= '0;
        cnt_r   <= '0;
        first_r <= '0;
        type_r  <= '0;
      end else begin
        crc_r   <= crc_nxt;
        hold0_r <= hold0_nxt;
        hold1_r <= hold1_nxt;
        cnt_r   <= cnt_nxt;
        first_r <= first_nxt;
        type_r  <= type_nxt;
      end
    end
  end

  // Two-entry output queue: out_r is the head, skid_r holds a word behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || pop) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= push;
        end else begin
          out_valid_r  <= push;
        end
      end else if (push) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_r  <= skid_r;
        skid_r <= res_nxt;
      end else begin
        out_r  <= res_nxt;
      end
    end else if (push) begin
      skid_r <= res_nxt;
    end
  end

  assign in_stall           = skid_valid_r;
  assign out_valid          = out_valid_r;
  assign out_verdict        = out_r.verdict;
  assign out_packet_type    = out_r.packet_type;
  assign out_payload_length = out_r.payload_length;

  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("queue tail holds a word while head is empty");

  a_stalled_push_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && push) |=> skid_valid_r)
    else $error("result lost while head stalled");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (cnt_r == '0 && crc_r == pcc_pkg::CRC_INIT))
    else $error("packet state not cleared after last word");

  a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_last_byte) |=> cnt_r != '0)
    else $error("byte count did not advance");

  a_short_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.verdict == pcc_pkg::VERDICT_TOO_SHORT)
      |-> (out_r.packet_type == 8'h00 && out_r.payload_length == 16'h0000))
    else $error("short packet reports type or length");

endmodule

`default_nettype wire

[verif/packet_crc16_checker_monitor.sv]
// Watches both channels of the packet CRC16 checker, predicts every verdict and compares.
`timescale 1ns / 1ps

module packet_crc16_checker_monitor (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_wr_en,
  input  wire  [7:0]  cfg_wr_data,
  input  wire         in_valid,
  input  wire         in_stall,
  input  wire  [7:0]  in_data_byte,
  input  wire         in_last_byte,
  input  wire         out_valid,
  input  wire         out_stall,
  input  wire  [1:0]  out_verdict,
  input  wire  [7:0]  out_packet_type,
  input  wire  [15:0] out_payload_length,
  output int          mismatch_count,
  output int          pending_results
);

  pcc_pkg::result_t pending_verdicts[$];
  logic [15:0]      crc_acc;
  logic [7:0]       held_bytes[2];
  logic [15:0]      seen_count;
  logic [7:0]       lead_byte;
  logic [7:0]       type_seen;
  logic [7:0]       header_reg;

  function automatic logic [15:0] crc16_ccitt_next(input logic [15:0] crc,
                                                   input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ pcc_pkg::CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  task automatic clear_packet_state();
    crc_acc       = pcc_pkg::CRC_INIT;
    held_bytes[0] = 8'h00;
    held_bytes[1] = 8'h00;
    seen_count    = 16'h0000;
    lead_byte     = 8'h00;
    type_seen     = 8'h00;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last);
    pcc_pkg::result_t r;
    // The two newest words are held back, so the trailer never enters the sum.
    if (seen_count >= 16'd2) begin
      crc_acc = crc16_ccitt_next(crc_acc, held_bytes[0]);
    end
    held_bytes[0] = held_bytes[1];
    held_bytes[1] = b;
    if (seen_count == 16'd0) begin
      lead_byte = b;
    end else if (seen_count == 16'd1) begin
      type_seen = b;
    end
    if (seen_count != 16'hFFFF) begin
      seen_count = seen_count + 16'd1;
    end
    if (last) begin
      if (seen_count < pcc_pkg::MIN_LENGTH) begin
        r.verdict        = pcc_pkg::VERDICT_TOO_SHORT;
        r.packet_type    = 8'h00;
        r.payload_length = 16'h0000;
      end else begin
        r.payload_length = seen_count - 16'(pcc_pkg::MIN_LENGTH);
        if (lead_byte != header_reg) begin
          r.verdict     = pcc_pkg::VERDICT_BAD_HDR;
          r.packet_type = 8'h00;
        end else begin
          r.packet_type = type_seen;
          r.verdict     = ({held_bytes[0], held_bytes[1]} == crc_acc)
                          ? pcc_pkg::VERDICT_OK : pcc_pkg::VERDICT_CRC_ERR;
        end
      end
      pending_verdicts.push_back(r);
      clear_packet_state();
    end
  endtask

  task automatic compare_result();
    pcc_pkg::result_t e;
    if (pending_verdicts.size() == 0) begin
      mismatch_count++;
      $display("%0t: unexpected result, verdict %0d type %0h length %0d", $time,
               out_verdict, out_packet_type, out_payload_length);
    end else begin
      e = pending_verdicts.pop_front();
      if (out_verdict !== e.verdict) begin
        mismatch_count++;
        $display("%0t: verdict expected %0d (%s) actual %0d", $time, e.verdict,
                 e.verdict.name(), out_verdict);
      end
      if (out_packet_type !== e.packet_type) begin
        mismatch_count++;
        $display("%0t: packet_type expected %0h actual %0h", $time, e.packet_type,
                 out_packet_type);
      end
      if (out_payload_length !== e.payload_length) begin
        mismatch_count++;
        $display("%0t: payload_length expected %0d actual %0d", $time, e.payload_length,
                 out_payload_length);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      header_reg = pcc_pkg::HEADER_RST;
      pending_verdicts.delete();
      clear_packet_state();
      mismatch_count = 0;
    end else begin
      if (cfg_wr_en) begin
        header_reg = cfg_wr_data;
      end
      // Results accepted now belong to packets that ended earlier.
      if (out_valid && !out_stall) begin
        compare_result();
      end
      if (in_valid && !in_stall) begin
        predict_byte(in_data_byte, in_last_byte);
      end
    end
    pending_results = pending_verdicts.size();
  end

endmodule

[verif/packet_crc16_checker_test.sv]
// Stimulus and verdict for the packet CRC16 checker: packets, header writes and stalls.
`timescale 1ns / 1ps

module packet_crc16_checker_test;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;
  logic        in_valid = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_stall = 1'b0;
  wire         in_stall;
  wire         out_valid;
  wire  [1:0]  out_verdict;
  wire  [7:0]  out_packet_type;
  wire  [15:0] out_payload_length;
  int          mismatch_count;
  int          pending_results;

  int          bytes_sent = 0;
  int          burst_left = 0;
  int          stall_left = 0;
  int          stall_mode = 0;
  logic [7:0]  header_cfg = pcc_pkg::HEADER_RST;

  packet_crc16_checker i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_verdict        (out_verdict),
    .out_packet_type    (out_packet_type),
    .out_payload_length (out_payload_length)
  );

  packet_crc16_checker_monitor i_monitor (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_verdict        (out_verdict),
    .out_packet_type    (out_packet_type),
    .out_payload_length (out_payload_length),
    .mismatch_count     (mismatch_count),
    .pending_results    (pending_results)
  );

  always #6 clk = ~clk;

  // Receiver back-pressure: switch between free flow, random, heavy and periodic stalls.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(40, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((stall_left % 5) < 2);
    endcase
  end

  function automatic logic [15:0] trailer_crc_step(input logic [15:0] crc,
                                                   input logic [7:0] b);
    logic [15:0] c;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      c = (c[15] ^ b[k]) ? ({c[14:0], 1'b0} ^ pcc_pkg::CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // Enter at a falling edge; return at the falling edge after the word is taken.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    bytes_sent++;
  endtask

  // fill < 0 gives random payload words; the trailer is the CRC unless crc_ok is clear.
  task automatic send_packet(input logic [7:0] hdr, input logic [7:0] ptype, input int len,
                             input int fill, input bit crc_ok);
    logic [7:0]  pkt[];
    logic [15:0] sum;
    pkt = new[len];
    for (int i = 0; i < len; i++) begin
      if (i == 0) begin
        pkt[i] = hdr;
      end else if (i == 1) begin
        pkt[i] = ptype;
      end else begin
        pkt[i] = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
      end
    end
    if (len >= pcc_pkg::MIN_LENGTH) begin
      sum = pcc_pkg::CRC_INIT;
      for (int i = 0; i < len - 2; i++) begin
        sum = trailer_crc_step(sum, pkt[i]);
      end
      if (!crc_ok) begin
        sum = sum ^ 16'($urandom_range(1, 65535));
      end
      pkt[len - 2] = sum[15:8];
      pkt[len - 1] = sum[7:0];
    end
    for (int i = 0; i < len; i++) begin
      send_byte(pkt[i], i == len - 1);
    end
  endtask

  // Write only once every result is out and the pipeline has settled.
  task automatic write_header(input logic [7:0] v);
    in_valid <= 1'b0;
    wait (pending_results == 0);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en  <= 1'b0;
    header_cfg = v;
  endtask

  initial begin
    int          len;
    int          pick;
    int          reconfigs;
    logic [7:0]  hdr;
    logic [7:0]  v;

    reconfigs = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed packets, all against the header value left by reset.
    send_packet(pcc_pkg::HEADER_RST, 8'h00, 1, -1, 1);
    send_packet(pcc_pkg::HEADER_RST, 8'h5A, 2, -1, 1);
    send_packet(pcc_pkg::HEADER_RST, 8'h33, 3, -1, 1);
    send_packet(8'h55, 8'h12, 3, -1, 1);
    send_packet(pcc_pkg::HEADER_RST, 8'h00, 4, 0, 1);
    send_packet(8'h00, 8'hFF, 4, 0, 0);
    send_packet(pcc_pkg::HEADER_RST, 8'hFF, 5, 255, 1);
    send_packet(pcc_pkg::HEADER_RST, 8'h7E, 5, -1, 0);

    while (bytes_sent < 1050) begin
      if (reconfigs < 2 ? bytes_sent > 150 * (reconfigs + 1) : $urandom_range(0, 9) == 0) begin
        case (reconfigs)
          0: v = 8'h00;
          1: v = 8'hFF;
          default: v = 8'($urandom_range(0, 255));
        endcase
        write_header(v);
        reconfigs++;
      end
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        len = $urandom_range(1, 3);
      end else if (pick < 18) begin
        len = $urandom_range(4, 24);
      end else begin
        len = $urandom_range(25, 90);
      end
      hdr = ($urandom_range(0, 4) != 0) ? header_cfg : 8'($urandom_range(0, 255));
      send_packet(hdr, 8'($urandom_range(0, 255)), len, -1, $urandom_range(0, 3) != 0);
    end

    in_valid <= 1'b0;
    wait (pending_results == 0);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

[files.f]
rtl/pcc_pkg.sv
rtl/packet_crc16_checker.sv
verif/packet_crc16_checker_monitor.sv
verif/packet_crc16_checker_test.sv
